@@ hdl/sobel_horizontal_gradient_stream_defines.svh @@
// Assertion macros shared by the Sobel gradient stream RTL.
`ifndef SOBEL_HORIZONTAL_GRADIENT_STREAM_DEFINES_SVH
`define SOBEL_HORIZONTAL_GRADIENT_STREAM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SGS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SGS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/sgs_pkg.sv @@
// Package with widths, limits and register codes of the Sobel gradient stream.
package sgs_pkg;

  // Pixel and gradient width.
  localparam int PIX_W = 16;

  // Largest supported row length and the line store address width.
  localparam int MAX_COLUMNS = 1024;
  localparam int COL_AW      = $clog2(MAX_COLUMNS);

  // Configuration register widths.
  localparam int COL_CNT_W  = 11;
  localparam int ROW_CNT_W  = 16;
  localparam int CFG_DATA_W = (COL_CNT_W > ROW_CNT_W) ? COL_CNT_W : ROW_CNT_W;
  localparam int CFG_IDX_W  = 1;

  // Width that holds both the column count register and MAX_COLUMNS.
  localparam int COL_CMP_W = (COL_CNT_W > COL_AW + 1) ? COL_CNT_W : COL_AW + 1;

  // Reset values and smallest frame dimension.
  localparam int COL_CNT_RESET = 640;
  localparam int ROW_CNT_RESET = 480;
  localparam int MIN_DIM       = 3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLUMNS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS    = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

@@ hdl/sgs_pixel_if.sv @@
// Pixel input channel: valid/ready handshake with one signed pixel per word.
interface sgs_pixel_if;
  logic                             valid;
  logic                             ready;
  logic signed [sgs_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface

@@ hdl/sgs_grad_if.sv @@
// Gradient output channel: valid/ready handshake with gradient and end flags.
interface sgs_grad_if;
  logic                             valid;
  logic                             ready;
  logic signed [sgs_pkg::PIX_W-1:0] gradient;
  logic                             row_end;
  logic                             frame_end;

  modport source (output valid, output gradient, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input gradient, input row_end, input frame_end,
                output ready);
endinterface

@@ hdl/sgs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module sgs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/sobel_horizontal_gradient_stream.sv @@
// Horizontal 3x3 Sobel gradient over a raster pixel stream, two line stores in RAM.
// Throughput: one pixel word per cycle while the output is not stalled.
// The pixel address is read from both line RAMs in the accept cycle; when stage one
// moves on, it forms the gradient, writes rows back and loads the output register.
// Reset (synchronous, rst_n low) clears positions, window and handshake state and
// loads 640 columns and 480 rows; the line RAMs are not cleared.
`include "sobel_horizontal_gradient_stream_defines.svh"

module sobel_horizontal_gradient_stream (
  input  logic                                clk,
  input  logic                                rst_n,
  sgs_pixel_if.sink                           in_pix,
  sgs_grad_if.source                          out_grad,
  input  logic                                cfg_we,
  input  logic [sgs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgs_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = sgs_pkg::COL_AW;
  localparam int CW = sgs_pkg::COL_CMP_W;
  localparam int RW = sgs_pkg::ROW_CNT_W;

  // Configuration registers.
  logic [sgs_pkg::COL_CNT_W-1:0] col_count_r;
  logic [RW-1:0]                 row_count_r;

  // Raster position of the next pixel.
  logic [AW-1:0] col_pos_r, col_pos_nxt;
  logic [RW-1:0] row_pos_r, row_pos_nxt;

  // Stage one: pixel whose line store reads are in flight.
  logic          s1_valid_r;
  logic [AW-1:0] s1_col_r;
  sgs_pkg::pix_t s1_px_r;
  logic          s1_emit_r;
  logic          s1_row_end_r;
  logic          s1_frame_end_r;

  // Window: [0..2] column c-2 (top, mid, bottom), [3..5] column c-1.
  sgs_pkg::pix_t window_r [6];

  // Output register.
  logic          out_valid_r;
  sgs_pkg::pix_t out_grad_r;
  logic          out_row_end_r;
  logic          out_frame_end_r;

  logic          in_acc;
  logic          s1_adv;
  logic [CW-1:0] cc_ext;
  logic [CW-1:0] cols_eff;
  logic [CW-1:0] cols_m1_full;
  logic [AW-1:0] cols_m1;
  logic [RW-1:0] rows_m1;
  logic [AW-1:0] col0;
  logic [RW-1:0] row0;
  logic          last_col0;
  logic          last_row0;
  logic          emit0;
  sgs_pkg::pix_t top_rd;
  sgs_pkg::pix_t mid_rd;
  sgs_pkg::pix_t left_sum;
  sgs_pkg::pix_t right_sum;
  sgs_pkg::pix_t grad_nxt;

  // Handshake: stage one moves on whenever the output register is free or drained.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_grad.ready);
  assign in_pix.ready = !s1_valid_r || s1_adv;
  assign in_acc       = in_pix.valid && in_pix.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r <= sgs_pkg::COL_CNT_W'(sgs_pkg::COL_CNT_RESET);
      row_count_r <= RW'(sgs_pkg::ROW_CNT_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgs_pkg::CFG_IDX_COLUMNS: col_count_r <= cfg_data[sgs_pkg::COL_CNT_W-1:0];
        sgs_pkg::CFG_IDX_ROWS:    row_count_r <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size, clamped to the supported range.
  always_comb begin
    cc_ext = CW'(col_count_r);
    if (cc_ext < CW'(sgs_pkg::MIN_DIM)) begin
      cols_eff = CW'(sgs_pkg::MIN_DIM);
    end else if (cc_ext > CW'(sgs_pkg::MAX_COLUMNS)) begin
      cols_eff = CW'(sgs_pkg::MAX_COLUMNS);
    end else begin
      cols_eff = cc_ext;
    end
    cols_m1_full = cols_eff - CW'(1);
    cols_m1      = cols_m1_full[AW-1:0];
    if (row_count_r < RW'(sgs_pkg::MIN_DIM)) begin
      rows_m1 = RW'(sgs_pkg::MIN_DIM - 1);
    end else begin
      rows_m1 = row_count_r - RW'(1);
    end
  end

  // Position of the arriving pixel and whether it completes an interior window.
  always_comb begin
    col0      = (col_pos_r >= cols_m1) ? cols_m1 : col_pos_r;
    row0      = (row_pos_r >= rows_m1) ? rows_m1 : row_pos_r;
    last_col0 = (col0 == cols_m1);
    last_row0 = (row0 == rows_m1);
    emit0     = (row0 >= RW'(2)) && (col0 >= AW'(2));
    if (last_col0) begin
      col_pos_nxt = '0;
      row_pos_nxt = last_row0 ? '0 : row0 + RW'(1);
    end else begin
      col_pos_nxt = col0 + AW'(1);
      row_pos_nxt = row0;
    end
  end

  // Position counters and stage one register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_pos_r <= col_pos_nxt;
        row_pos_r <= row_pos_nxt;
      end
      if (in_pix.ready) begin
        s1_valid_r <= in_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r       <= col0;
      s1_px_r        <= in_pix.pixel_value;
      s1_emit_r      <= emit0;
      s1_row_end_r   <= last_col0;
      s1_frame_end_r <= last_col0 && last_row0;
    end
  end

  // Line stores: read in the accept cycle, written back when stage one moves on.
  // Read and write never hit the same column in one cycle, since a row holds at
  // least three columns.
  sgs_ram #(
    .WIDTH (sgs_pkg::PIX_W),
    .DEPTH (sgs_pkg::MAX_COLUMNS)
  ) u_upper_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (mid_rd),
    .re    (in_acc),
    .raddr (col0),
    .rdata (top_rd)
  );

  sgs_ram #(
    .WIDTH (sgs_pkg::PIX_W),
    .DEPTH (sgs_pkg::MAX_COLUMNS)
  ) u_middle_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_px_r),
    .re    (in_acc),
    .raddr (col0),
    .rdata (mid_rd)
  );

  // Gradient: left column minus right column, middle rows weighted by two.
  always_comb begin
    left_sum  = window_r[0] + window_r[2] + {window_r[1][sgs_pkg::PIX_W-2:0], 1'b0};
    right_sum = top_rd + s1_px_r + {mid_rd[sgs_pkg::PIX_W-2:0], 1'b0};
    grad_nxt  = left_sum - right_sum;
  end

  // Window shift by one column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        window_r[i] <= '0;
      end
    end else if (s1_adv) begin
      window_r[0] <= window_r[3];
      window_r[1] <= window_r[4];
      window_r[2] <= window_r[5];
      window_r[3] <= top_rd;
      window_r[4] <= mid_rd;
      window_r[5] <= s1_px_r;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_emit_r;
    end else if (out_grad.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_grad_r      <= grad_nxt;
      out_row_end_r   <= s1_row_end_r;
      out_frame_end_r <= s1_frame_end_r;
    end
  end

  assign out_grad.valid     = out_valid_r;
  assign out_grad.gradient  = out_grad_r;
  assign out_grad.row_end   = out_row_end_r;
  assign out_grad.frame_end = out_frame_end_r;

  // Input back-pressure only comes from a full stage one behind a stalled output.
  `SGS_ASSERT_NOW(a_ready_low_cause, !in_pix.ready, s1_valid_r && out_valid_r && !out_grad.ready, "input stalled without output stall")
  // The frame end flag only comes with the row end flag.
  `SGS_ASSERT_NOW(a_frame_end_row_end, out_valid_r && out_frame_end_r, out_row_end_r, "frame end without row end")
  // An interior pixel leaving stage one shows up as a result next cycle.
  `SGS_ASSERT_NEXT(a_emit_reaches_out, s1_adv && s1_emit_r, out_valid_r, "interior result lost")
  // An accepted pixel sits in stage one next cycle.
  `SGS_ASSERT_NEXT(a_accept_fills_s1, in_acc, s1_valid_r, "accepted pixel lost")

endmodule
